FILE: rtl/core/wsc_pkg.sv
// wsc_pkg: shared types and constants of the wall segment column projector
// used by wsc_col_store and wall_segment_column_projector; no dependencies
package wsc_pkg;

  typedef enum logic [1:0] {
    REQ_FRAME   = 2'd0,
    REQ_LOAD    = 2'd1,
    REQ_SEGMENT = 2'd2,
    REQ_QUERY   = 2'd3
  } req_e;

  // one column slice as held in the column store
  typedef struct packed {
    logic               valid;
    logic        [24:0] depth;
    logic signed [15:0] ceil_row;
    logic signed [15:0] floor_row;
    logic        [2:0]  texture;
    logic        [5:0]  texel;
    logic        [6:0]  side;
  } col_entry_t;

  localparam logic signed [31:0] NEAR_Z     = 32'sd8192;
  localparam logic signed [31:0] U_ONE      = 32'sd65536;
  localparam logic signed [31:0] CENTER_X   = 32'sd10485760;
  localparam logic signed [63:0] INV_ONE    = 64'sd16777216;
  localparam logic signed [63:0] HEIGHT_NUM = 64'sd4194304;
  localparam logic signed [15:0] ROWS2      = 16'sd200;
  localparam logic        [7:0]  NO_SIDE    = 8'd128;

endpackage

FILE: rtl/core/wsc_div.sv
// wsc_div: shared signed divider, 64-bit dividend by 32-bit divisor
// restoring, one quotient bit per cycle, truncates toward zero; no dependencies
module wsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] dividend_i,
  input  logic signed [31:0] divisor_i,
  output logic               done_o,
  output logic signed [63:0] quot_o
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} dstate_e;

  dstate_e     st_q, st_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] num_q, quo_q;
  logic [31:0] rem_q, den_q;
  logic        neg_q;

  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] rem_sub;

  assign rem_sh  = {rem_q, num_q[63]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    unique case (st_q)
      D_IDLE: begin
        if (start_i) begin
          st_d  = D_RUN;
          cnt_d = '0;
        end
      end
      D_RUN: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) st_d = D_DONE;
      end
      D_DONE: st_d = D_IDLE;
      default: st_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= D_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == D_IDLE && start_i) begin
      num_q <= dividend_i[63] ? 64'(-dividend_i) : 64'(dividend_i);
      den_q <= divisor_i[31] ? 32'(-divisor_i) : 32'(divisor_i);
      neg_q <= dividend_i[63] ^ divisor_i[31];
      rem_q <= '0;
      quo_q <= '0;
    end else if (st_q == D_RUN) begin
      num_q <= {num_q[62:0], 1'b0};
      rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = (st_q == D_DONE);
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: rtl/core/wsc_col_store.sv
// wsc_col_store: per-column slice memory, one write and one registered read port
// depends on wsc_pkg for the entry type
module wsc_col_store #(
  parameter int DEPTH = 320,
  parameter int AW    = 9
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  wsc_pkg::col_entry_t wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output wsc_pkg::col_entry_t rdata_o
);

  wsc_pkg::col_entry_t mem [DEPTH];
  wsc_pkg::col_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/wall_segment_column_projector.sv
// One request beat at a time: frame start, sidedef load, wall segment or column query.
// A frame start (and reset) runs a clearing pass over every column of the column
// store; a load writes an in-range sidedef slot without leaving idle, and a query
// reads the store and then registers its answer. A segment is set up with up to eight
// divisions and then walked one column at a time; each column costs two divisions
// when a nearer slice is held and five when a slice is written, every division
// running in the single shared bit-serial divider.
// The input side stays ready while a query result waits in the output register.
module wall_segment_column_projector #(
  parameter int SCREEN_W     = 320,
  parameter int POOL_MAX     = 2048,
  parameter int SIDE_ENTRIES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_z_i,
  input  logic [7:0]         front_side_i,
  input  logic [7:0]         back_side_i,
  input  logic [8:0]         column_i,
  input  logic [6:0]         side_slot_i,
  input  logic [2:0]         side_texture_i,
  input  logic [15:0]        side_width_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic signed [15:0] ceil_row_o,
  output logic signed [15:0] floor_row_o,
  output logic [24:0]        depth_o,
  output logic [2:0]         texture_num_o,
  output logic [5:0]         texel_col_o,
  output logic [6:0]         side_id_o
);

  localparam int CAW    = $clog2(SCREEN_W);
  localparam int SLW    = $clog2(POOL_MAX + 1);
  localparam int SIDX_W = (SIDE_ENTRIES > 1) ? $clog2(SIDE_ENTRIES) : 1;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_QRD, S_QOUT, S_SEG,
    S_CDX_MUL, S_CDX_GO, S_CDX_WT, S_CU_GO, S_CU_WT,
    S_P1_GO, S_P1_WT, S_P2_GO, S_P2_WT, S_ORDER,
    S_D1_GO, S_D1_WT, S_D2_GO, S_D2_WT,
    S_W1_MUL, S_W1_GO, S_W1_WT, S_W2_MUL, S_W2_GO, S_W2_WT,
    S_COL, S_ID_MUL, S_ID_GO, S_ID_WT, S_D_GO, S_D_WT, S_CMP,
    S_T_MUL, S_T_GO, S_T_WT, S_TX_GO, S_TX_WT, S_H_GO, S_H_WT, S_WR
  } state_e;

  // control
  state_e             state_q, state_d;
  logic [CAW-1:0]     clr_q, clr_d;
  logic [SLW-1:0]     slices_q, slices_d;
  logic signed [16:0] x_q, x_d;
  logic               out_valid_q, out_valid_d;
  logic               hit_q, hit_d;
  logic signed [15:0] ceil_q, ceil_d, floor_q, floor_d;
  logic [24:0]        depth_q, depth_d;
  logic [2:0]         otex_q, otex_d;
  logic [5:0]         otexel_q, otexel_d;
  logic [6:0]         oside_q, oside_d;

  // datapath
  logic signed [31:0] x1_q, x1_d, z1_q, z1_d, x2_q, x2_d, z2_q, z2_d;
  logic signed [31:0] u1_q, u1_d, u2_q, u2_d;
  logic [7:0]         fs_q, fs_d, bs_q, bs_d, sd_q, sd_d;
  logic signed [31:0] dx_q, dx_d, dy_q, dy_d, cdy_q, cdy_d, cdx_q, cdx_d;
  logic               end2_q, end2_d;
  logic signed [31:0] p1_q, p1_d, p2_q, p2_d;
  logic [15:0]        w_q, w_d;
  logic [2:0]         tex_q, tex_d;
  logic [13:0]        d1_q, d1_d, d2_q, d2_d, id_q, id_d;
  logic signed [15:0] ix_q, ix_d;
  logic signed [16:0] xe_q, xe_d, ixd_q, ixd_d;
  logic [24:0]        d_q, d_d;
  logic signed [31:0] tid_q, tid_d;
  logic [5:0]         texel_q, texel_d;
  logic [11:0]        h_q, h_d;
  logic [8:0]         col_q, col_d;
  logic               inr_q, inr_d;
  logic signed [63:0] prod_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic signed [17:0] xoff;

  // divider
  logic               div_start, div_done;
  logic signed [63:0] div_n, div_q;
  logic signed [31:0] div_d;

  // memories
  logic                col_we, col_re;
  logic [CAW-1:0]      col_waddr, col_raddr;
  wsc_pkg::col_entry_t col_wdata, col_rdata;
  logic                side_we, side_re;
  logic [SIDX_W-1:0]   side_raddr;
  logic [2:0]          side_tex_mem [SIDE_ENTRIES];
  logic [15:0]         side_w_mem [SIDE_ENTRIES];
  logic [2:0]          side_tex_rd;
  logic [15:0]         side_w_rd;

  logic in_fire;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  function automatic logic [32:0] mag33(input logic signed [31:0] v);
    mag33 = v[31] ? 33'(-$signed({v[31], v})) : 33'({1'b0, v});
  endfunction

  assign xoff = 18'({x_q[16], x_q}) - 18'(ix_q);

  always_comb begin
    unique case (state_q)
      S_CDX_MUL: begin mul_a = 33'(cdy_q); mul_b = 33'(dx_q); end
      S_W1_MUL:  begin mul_a = 33'({1'b0, w_q}); mul_b = 33'(u1_q); end
      S_W2_MUL:  begin mul_a = 33'({1'b0, w_q}); mul_b = 33'(u2_q); end
      S_ID_MUL:  begin
        mul_a = 33'(xoff);
        mul_b = 33'($signed({1'b0, d2_q})) - 33'($signed({1'b0, d1_q}));
      end
      S_T_MUL:   begin mul_a = 33'(xoff); mul_b = 33'(u2_q) - 33'(u1_q); end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[63:0];
  end

  // divider operand select
  always_comb begin
    logic               usedy;
    logic signed [31:0] csel;
    logic signed [63:0] cnum;
    usedy = mag33(dx_q) < mag33(dy_q);
    csel  = usedy ? cdy_q : cdx_q;
    cnum  = end2_q ? 64'(csel) : -64'(csel);
    div_start = 1'b1;
    unique case (state_q)
      S_CDX_GO: begin div_n = prod_q; div_d = dy_q; end
      S_CU_GO:  begin div_n = cnum <<< 16; div_d = usedy ? dy_q : dx_q; end
      S_P1_GO:  begin div_n = 64'(x1_q) <<< 22; div_d = z1_q >>> 2; end
      S_P2_GO:  begin div_n = 64'(x2_q) <<< 22; div_d = z2_q >>> 2; end
      S_D1_GO:  begin div_n = wsc_pkg::INV_ONE; div_d = z1_q >>> 2; end
      S_D2_GO:  begin div_n = wsc_pkg::INV_ONE; div_d = z2_q >>> 2; end
      S_W1_GO:  begin div_n = prod_q; div_d = z1_q >>> 2; end
      S_W2_GO:  begin div_n = prod_q; div_d = z2_q >>> 2; end
      S_ID_GO:  begin div_n = prod_q; div_d = 32'(ixd_q); end
      S_D_GO:   begin div_n = wsc_pkg::INV_ONE; div_d = 32'({1'b0, id_q}); end
      S_T_GO:   begin div_n = prod_q; div_d = 32'(ixd_q); end
      S_TX_GO:  begin
        div_n = 64'($signed({tid_q[23:0], 8'b0}));
        div_d = 32'({1'b0, id_q});
      end
      S_H_GO:   begin div_n = wsc_pkg::HEIGHT_NUM; div_d = 32'({1'b0, d_q}); end
      default:  begin div_n = '0; div_d = '0; div_start = 1'b0; end
    endcase
  end

  wsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  wsc_col_store #(
    .DEPTH (SCREEN_W),
    .AW    (CAW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (col_wdata),
    .re_i    (col_re),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata)
  );

  // sidedef table
  always_ff @(posedge clk_i) begin
    if (side_we) begin
      side_tex_mem[SIDX_W'(side_slot_i)] <= side_texture_i;
      side_w_mem[SIDX_W'(side_slot_i)]   <= side_width_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (side_re) begin
      side_tex_rd <= side_tex_mem[side_raddr];
      side_w_rd   <= side_w_mem[side_raddr];
    end
  end

  // sequencer
  always_comb begin
    logic               below1, below2, swap, sd_ok;
    logic [7:0]         sdsel;
    logic signed [31:0] idsum;
    logic signed [15:0] xe_raw;
    logic signed [15:0] ctmp, ftmp;
    below1 = z1_q < wsc_pkg::NEAR_Z;
    below2 = z2_q < wsc_pkg::NEAR_Z;
    swap   = p1_q > p2_q;
    sdsel  = swap ? bs_q : fs_q;
    sd_ok  = (sdsel != wsc_pkg::NO_SIDE) && ({1'b0, sdsel} < 9'(SIDE_ENTRIES));
    idsum  = 32'($signed({1'b0, d1_q})) + div_q[31:0];
    xe_raw = p2_q[31:16];
    ctmp   = wsc_pkg::ROWS2 - $signed({4'b0, h_q});
    ftmp   = wsc_pkg::ROWS2 + $signed({4'b0, h_q});

    state_d = state_q; clr_d = clr_q; slices_d = slices_q; x_d = x_q;
    out_valid_d = out_valid_q; hit_d = hit_q; ceil_d = ceil_q; floor_d = floor_q;
    depth_d = depth_q; otex_d = otex_q; otexel_d = otexel_q; oside_d = oside_q;
    x1_d = x1_q; z1_d = z1_q; x2_d = x2_q; z2_d = z2_q; u1_d = u1_q; u2_d = u2_q;
    fs_d = fs_q; bs_d = bs_q; sd_d = sd_q;
    dx_d = dx_q; dy_d = dy_q; cdy_d = cdy_q; cdx_d = cdx_q; end2_d = end2_q;
    p1_d = p1_q; p2_d = p2_q; w_d = w_q; tex_d = tex_q;
    d1_d = d1_q; d2_d = d2_q; id_d = id_q; ix_d = ix_q; xe_d = xe_q; ixd_d = ixd_q;
    d_d = d_q; tid_d = tid_q; texel_d = texel_q; h_d = h_q; col_d = col_q; inr_d = inr_q;

    col_we = 1'b0; col_waddr = clr_q; col_wdata = '0;
    col_re = 1'b0; col_raddr = CAW'(x_q);
    side_we = 1'b0; side_re = 1'b0; side_raddr = SIDX_W'(sdsel);

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_CLR: begin
        col_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == CAW'(SCREEN_W - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (wsc_pkg::req_e'(req_type_i))
            wsc_pkg::REQ_FRAME: begin
              state_d = S_CLR; clr_d = '0; slices_d = '0;
            end
            wsc_pkg::REQ_LOAD: begin
              side_we = {2'b0, side_slot_i} < 9'(SIDE_ENTRIES);
            end
            wsc_pkg::REQ_SEGMENT: begin
              state_d = S_SEG;
              x1_d = start_x_i; z1_d = start_z_i; x2_d = end_x_i; z2_d = end_z_i;
              fs_d = front_side_i; bs_d = back_side_i;
              u1_d = '0; u2_d = wsc_pkg::U_ONE;
            end
            wsc_pkg::REQ_QUERY: begin
              state_d = S_QRD; col_d = column_i;
              inr_d = 11'(column_i) < 11'(SCREEN_W);
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_QRD: begin
        col_re = 1'b1; col_raddr = CAW'(col_q);
        state_d = S_QOUT;
      end
      S_QOUT: begin
        // hold the answer until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          hit_d    = inr_q && col_rdata.valid;
          ceil_d   = hit_d ? col_rdata.ceil_row : '0;
          floor_d  = hit_d ? col_rdata.floor_row : '0;
          depth_d  = hit_d ? col_rdata.depth : '0;
          otex_d   = hit_d ? col_rdata.texture : '0;
          otexel_d = hit_d ? col_rdata.texel : '0;
          oside_d  = hit_d ? col_rdata.side : '0;
          state_d  = S_IDLE;
        end
      end
      S_SEG: begin
        dx_d = x2_q - x1_q; dy_d = z2_q - z1_q; end2_d = below2;
        cdy_d = below2 ? wsc_pkg::NEAR_Z - z1_q : wsc_pkg::NEAR_Z - z2_q;
        if (below1 && below2) state_d = S_IDLE;
        else if (below1 || below2) state_d = S_CDX_MUL;
        else state_d = S_P1_GO;
      end
      S_CDX_MUL: state_d = S_CDX_GO;
      S_CDX_GO:  state_d = S_CDX_WT;
      S_CDX_WT: begin
        if (div_done) begin cdx_d = div_q[31:0]; state_d = S_CU_GO; end
      end
      S_CU_GO: state_d = S_CU_WT;
      S_CU_WT: begin
        if (div_done) begin
          if (end2_q) begin
            u2_d = div_q[31:0]; x2_d = x1_q + cdx_q; z2_d = wsc_pkg::NEAR_Z;
          end else begin
            u1_d = wsc_pkg::U_ONE - div_q[31:0]; x1_d = x2_q + cdx_q;
            z1_d = wsc_pkg::NEAR_Z;
          end
          state_d = S_P1_GO;
        end
      end
      S_P1_GO: state_d = S_P1_WT;
      S_P1_WT: begin
        if (div_done) begin p1_d = wsc_pkg::CENTER_X + div_q[31:0]; state_d = S_P2_GO; end
      end
      S_P2_GO: state_d = S_P2_WT;
      S_P2_WT: begin
        if (div_done) begin p2_d = wsc_pkg::CENTER_X + div_q[31:0]; state_d = S_ORDER; end
      end
      S_ORDER: begin
        // right-to-left ends: flip and take the back face
        if (swap) begin
          p1_d = p2_q; p2_d = p1_q; z1_d = z2_q; z2_d = z1_q; u1_d = u2_q; u2_d = u1_q;
        end
        sd_d = sdsel; side_re = 1'b1;
        state_d = sd_ok ? S_D1_GO : S_IDLE;
      end
      S_D1_GO: begin
        w_d = side_w_rd; tex_d = side_tex_rd;
        ix_d  = p1_q[31:16];
        ixd_d = 17'(xe_raw) - 17'($signed(p1_q[31:16]));
        xe_d  = (17'(xe_raw) > $signed(17'(SCREEN_W))) ? $signed(17'(SCREEN_W))
                                                       : 17'(xe_raw);
        state_d = S_D1_WT;
      end
      S_D1_WT: if (div_done) begin d1_d = div_q[13:0]; state_d = S_D2_GO; end
      S_D2_GO: state_d = S_D2_WT;
      S_D2_WT: if (div_done) begin d2_d = div_q[13:0]; state_d = S_W1_MUL; end
      S_W1_MUL: state_d = S_W1_GO;
      S_W1_GO:  state_d = S_W1_WT;
      S_W1_WT: if (div_done) begin u1_d = div_q[31:0]; state_d = S_W2_MUL; end
      S_W2_MUL: state_d = S_W2_GO;
      S_W2_GO:  state_d = S_W2_WT;
      S_W2_WT: begin
        if (div_done) begin
          u2_d = div_q[31:0];
          x_d  = ix_q[15] ? '0 : 17'({1'b0, ix_q});
          state_d = S_COL;
        end
      end
      S_COL: begin
        if (!(x_q < xe_q) || slices_q >= SLW'(POOL_MAX)) begin
          state_d = S_IDLE;
        end else begin
          col_re = 1'b1;
          state_d = S_ID_MUL;
        end
      end
      S_ID_MUL: state_d = S_ID_GO;
      S_ID_GO:  state_d = S_ID_WT;
      S_ID_WT: begin
        if (div_done) begin
          id_d = (idsum <= 32'sd0) ? 14'd1 : idsum[13:0];
          state_d = S_D_GO;
        end
      end
      S_D_GO: state_d = S_D_WT;
      S_D_WT: if (div_done) begin d_d = div_q[24:0]; state_d = S_CMP; end
      S_CMP: begin
        // a nearer slice already held: skip without using the pool
        if (col_rdata.valid && d_q > col_rdata.depth) begin
          x_d = x_q + 17'sd1; state_d = S_COL;
        end else begin
          state_d = S_T_MUL;
        end
      end
      S_T_MUL: state_d = S_T_GO;
      S_T_GO:  state_d = S_T_WT;
      S_T_WT: if (div_done) begin tid_d = u1_q + div_q[31:0]; state_d = S_TX_GO; end
      S_TX_GO: state_d = S_TX_WT;
      S_TX_WT: if (div_done) begin texel_d = div_q[5:0]; state_d = S_H_GO; end
      S_H_GO: state_d = S_H_WT;
      S_H_WT: if (div_done) begin h_d = div_q[11:0]; state_d = S_WR; end
      S_WR: begin
        col_we    = 1'b1;
        col_waddr = CAW'(x_q);
        col_wdata.valid     = 1'b1;
        col_wdata.depth     = d_q;
        col_wdata.ceil_row  = ctmp >>> 1;
        col_wdata.floor_row = ftmp >>> 1;
        col_wdata.texture   = tex_q;
        col_wdata.texel     = texel_q;
        col_wdata.side      = sd_q[6:0];
        slices_d = slices_q + 1'b1;
        x_d      = x_q + 17'sd1;
        state_d  = S_COL;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      slices_q    <= '0;
      x_q         <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      ceil_q      <= '0;
      floor_q     <= '0;
      depth_q     <= '0;
      otex_q      <= '0;
      otexel_q    <= '0;
      oside_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      slices_q    <= slices_d;
      x_q         <= x_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      ceil_q      <= ceil_d;
      floor_q     <= floor_d;
      depth_q     <= depth_d;
      otex_q      <= otex_d;
      otexel_q    <= otexel_d;
      oside_q     <= oside_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q <= x1_d; z1_q <= z1_d; x2_q <= x2_d; z2_q <= z2_d;
    u1_q <= u1_d; u2_q <= u2_d;
    fs_q <= fs_d; bs_q <= bs_d; sd_q <= sd_d;
    dx_q <= dx_d; dy_q <= dy_d; cdy_q <= cdy_d; cdx_q <= cdx_d; end2_q <= end2_d;
    p1_q <= p1_d; p2_q <= p2_d; w_q <= w_d; tex_q <= tex_d;
    d1_q <= d1_d; d2_q <= d2_d; id_q <= id_d;
    ix_q <= ix_d; xe_q <= xe_d; ixd_q <= ixd_d;
    d_q <= d_d; tid_q <= tid_d; texel_q <= texel_d; h_q <= h_d;
    col_q <= col_d; inr_q <= inr_d;
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign ceil_row_o    = ceil_q;
  assign floor_row_o   = floor_q;
  assign depth_o       = depth_q;
  assign texture_num_o = otex_q;
  assign texel_col_o   = otexel_q;
  assign side_id_o     = oside_q;

`ifndef SYNTHESIS
  a_pool_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slices_q <= SLW'(POOL_MAX))
    else $error("slice count above pool cap");

  a_col_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_we |-> ({1'b0, col_waddr} < (CAW + 1)'(SCREEN_W)))
    else $error("column write beyond screen width");

  a_seg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req_type_i == wsc_pkg::REQ_SEGMENT) |=> !in_ready_o)
    else $error("ready held while a segment is in flight");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_QOUT))
    else $error("result beat raised outside query answer");
`endif

endmodule
